// File: design/assert_macros.svh
// Assertion macros shared by the decoder RTL.
// No dependencies; included by files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge, disabled while reset is held.
`define HBKD_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Checked on every edge, reset included.
`define HBKD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// File: design/hbkd_pkg.sv
// Types, constants and key translation for the HID boot report decoder.
// No dependencies.
`default_nettype none

package hbkd_pkg;

    localparam int KEY_SLOTS    = 6;
    localparam int REPORT_SLOTS = 6;
    localparam int Q_DEPTH      = 2;
    localparam int Q_PTR_W      = 1;
    localparam int Q_CNT_W      = 2;

    localparam logic [6:0] MIN_REPORT_LEN  = 7'd8;
    localparam logic [7:0] MAX_RESERVED    = 8'h03;
    localparam logic [7:0] FIRST_PRINTABLE = 8'h04;
    localparam logic [7:0] LAST_PRINTABLE  = 8'h38;
    localparam int         LEFT_SHIFT_BIT  = 1;
    localparam int         RIGHT_SHIFT_BIT = 5;

    localparam logic [7:0] CODE_LEFT  = 8'h50;
    localparam logic [7:0] CODE_ENTER = 8'h28;
    localparam logic [7:0] CODE_UP    = 8'h52;
    localparam logic [7:0] CODE_RIGHT = 8'h4F;
    localparam logic [7:0] CODE_DOWN  = 8'h51;
    localparam logic [7:0] CODE_ESC   = 8'h29;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_JOY   = 2'd1,
        KIND_ASCII = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        JOY_LEFT  = 3'd0,
        JOY_ENTER = 3'd1,
        JOY_UP    = 3'd2,
        JOY_RIGHT = 3'd3,
        JOY_DOWN  = 3'd4,
        JOY_ESC   = 3'd5
    } joy_t;

    typedef logic [KEY_SLOTS-1:0][7:0] keys_t;
    typedef logic [KEY_SLOTS-1:0]      mask_t;

    // One accepted report with at least one new press.
    typedef struct packed {
        logic [7:0] modifier;
        keys_t      keys;
        mask_t      mask;
    } entry_t;

    typedef struct packed {
        kind_t      kind;
        logic [2:0] joy;
        logic [6:0] chr;
    } xlate_t;

    // {shifted, unshifted} ASCII for 0x04..0x38; zero means no character.
    function automatic logic [13:0] ascii_pair(input logic [7:0] code);
        logic [13:0] pair;
        pair = 14'd0;
        if (code >= 8'h04 && code <= 8'h1D) begin
            pair = {7'(8'h41 + code - 8'h04), 7'(8'h61 + code - 8'h04)};
        end
        else begin
            case (code)
                8'h1E: pair = {7'h21, 7'h31};
                8'h1F: pair = {7'h40, 7'h32};
                8'h20: pair = {7'h23, 7'h33};
                8'h21: pair = {7'h24, 7'h34};
                8'h22: pair = {7'h25, 7'h35};
                8'h23: pair = {7'h5E, 7'h36};
                8'h24: pair = {7'h26, 7'h37};
                8'h25: pair = {7'h2A, 7'h38};
                8'h26: pair = {7'h28, 7'h39};
                8'h27: pair = {7'h29, 7'h30};
                8'h28: pair = {7'h0D, 7'h0D};
                8'h2A: pair = {7'h00, 7'h08};
                8'h2C: pair = {7'h20, 7'h20};
                8'h2D: pair = {7'h5F, 7'h2D};
                8'h2E: pair = {7'h2B, 7'h3D};
                8'h2F: pair = {7'h7B, 7'h5B};
                8'h30: pair = {7'h7D, 7'h5D};
                8'h31: pair = {7'h7C, 7'h5C};
                8'h32: pair = {7'h7C, 7'h5C};
                8'h33: pair = {7'h3A, 7'h3B};
                8'h34: pair = {7'h22, 7'h27};
                8'h35: pair = {7'h7E, 7'h60};
                8'h36: pair = {7'h3C, 7'h2C};
                8'h37: pair = {7'h3E, 7'h2E};
                8'h38: pair = {7'h3F, 7'h2F};
                default: pair = 14'd0;
            endcase
        end
        return pair;
    endfunction

    function automatic xlate_t translate(input logic [7:0] modifier,
                                         input logic [7:0] code);
        xlate_t      r;
        logic [13:0] pair;
        logic [6:0]  ch;
        r    = '{kind: KIND_NONE, joy: 3'd0, chr: 7'd0};
        pair = ascii_pair(code);
        ch   = (modifier[LEFT_SHIFT_BIT] || modifier[RIGHT_SHIFT_BIT]) ?
               pair[13:7] : pair[6:0];
        case (code)
            CODE_LEFT:  r = '{kind: KIND_JOY, joy: JOY_LEFT,  chr: 7'd0};
            CODE_ENTER: r = '{kind: KIND_JOY, joy: JOY_ENTER, chr: 7'd0};
            CODE_UP:    r = '{kind: KIND_JOY, joy: JOY_UP,    chr: 7'd0};
            CODE_RIGHT: r = '{kind: KIND_JOY, joy: JOY_RIGHT, chr: 7'd0};
            CODE_DOWN:  r = '{kind: KIND_JOY, joy: JOY_DOWN,  chr: 7'd0};
            CODE_ESC:   r = '{kind: KIND_JOY, joy: JOY_ESC,   chr: 7'd0};
            default:
            begin
                if (code >= FIRST_PRINTABLE && code <= LAST_PRINTABLE && ch != 7'd0) begin
                    r = '{kind: KIND_ASCII, joy: 3'd0, chr: ch};
                end
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/hbkd_report_if.sv
// Report channel: valid/ready handshake carrying one boot keyboard report.
// No dependencies.
`default_nettype none

interface hbkd_report_if;
    logic       valid;
    logic       ready;
    logic [7:0] modifier_bits;
    logic [7:0] key_slot_0;
    logic [7:0] key_slot_1;
    logic [7:0] key_slot_2;
    logic [7:0] key_slot_3;
    logic [7:0] key_slot_4;
    logic [7:0] key_slot_5;
    logic [6:0] report_length;

    modport source (output valid, modifier_bits, key_slot_0, key_slot_1, key_slot_2,
                    key_slot_3, key_slot_4, key_slot_5, report_length, input ready);
    modport sink (input valid, modifier_bits, key_slot_0, key_slot_1, key_slot_2,
                  key_slot_3, key_slot_4, key_slot_5, report_length, output ready);
endinterface

`default_nettype wire

// File: design/hbkd_press_if.sv
// Press channel: valid/ready handshake carrying one decoded key press.
// No dependencies.
`default_nettype none

interface hbkd_press_if;
    logic       valid;
    logic       ready;
    logic [7:0] press_modifier;
    logic [7:0] press_keycode;
    logic [1:0] event_kind;
    logic [2:0] dir_index;
    logic [6:0] char_value;
    logic       last_of_report;

    modport source (output valid, press_modifier, press_keycode, event_kind,
                    dir_index, char_value, last_of_report, input ready);
    modport sink (input valid, press_modifier, press_keycode, event_kind,
                  dir_index, char_value, last_of_report, output ready);
endinterface

`default_nettype wire

// File: design/hbkd_front.sv
// Front end: takes reports, finds new presses against the previous report.
// Depends on hbkd_pkg and hbkd_report_if.
`default_nettype none

module hbkd_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    hbkd_report_if.sink          report,
    input  wire logic            q_full,
    output hbkd_pkg::entry_t     push_entry,
    output logic                 push
);

    hbkd_pkg::keys_t                          prev_reg;
    hbkd_pkg::keys_t                          prev_next;
    logic [hbkd_pkg::REPORT_SLOTS-1:0][7:0]  slots_in;
    hbkd_pkg::keys_t                          keys;
    hbkd_pkg::mask_t                          mask;
    logic                                     take;

    assign slots_in = {report.key_slot_5, report.key_slot_4, report.key_slot_3,
                       report.key_slot_2, report.key_slot_1, report.key_slot_0};

    assign report.ready = !q_full;
    assign take = report.valid && report.ready &&
                  (report.report_length >= hbkd_pkg::MIN_REPORT_LEN);

    always_comb
    begin
        logic seen;
        for (int i = 0; i < hbkd_pkg::KEY_SLOTS; i++) begin
            keys[i] = slots_in[i];
            seen = 1'b0;
            for (int j = 0; j < hbkd_pkg::KEY_SLOTS; j++) begin
                if (prev_reg[j] == slots_in[i]) begin
                    seen = 1'b1;
                end
            end
            mask[i] = (slots_in[i] > hbkd_pkg::MAX_RESERVED) && !seen;
        end
        prev_next = take ? keys : prev_reg;
    end

    assign push_entry = '{modifier: report.modifier_bits, keys: keys, mask: mask};
    assign push = take && (mask != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            prev_reg <= '0;
        end
        else begin
            prev_reg <= prev_next;
        end
    end

endmodule

`default_nettype wire

// File: design/hbkd_queue.sv
// Two-entry queue of pending reports between front and back end.
// Depends on hbkd_pkg.
`default_nettype none

module hbkd_queue (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire hbkd_pkg::entry_t           push_entry,
    input  wire logic                       pop,
    output hbkd_pkg::entry_t                head,
    output logic                            q_valid,
    output logic                            q_full,
    output logic [hbkd_pkg::Q_CNT_W-1:0]    count
);

    hbkd_pkg::entry_t                    mem_reg [hbkd_pkg::Q_DEPTH];
    logic [hbkd_pkg::Q_PTR_W-1:0]        wr_reg, wr_next;
    logic [hbkd_pkg::Q_PTR_W-1:0]        rd_reg, rd_next;
    logic [hbkd_pkg::Q_CNT_W-1:0]        cnt_reg, cnt_next;
    logic                                do_push, do_pop;

    assign q_valid = (cnt_reg != '0);
    assign q_full  = (cnt_reg == hbkd_pkg::Q_CNT_W'(hbkd_pkg::Q_DEPTH));
    assign head    = mem_reg[rd_reg];
    assign count   = cnt_reg;
    assign do_push = push && !q_full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// File: design/hbkd_back.sv
// Back end: walks the new-press mask one slot a cycle while press.ready allows, and emits results.
// Depends on hbkd_pkg and hbkd_press_if.
`default_nettype none

module hbkd_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire hbkd_pkg::entry_t  head,
    input  wire logic              q_valid,
    output logic                   pop,
    hbkd_press_if.source           press
);

    logic [7:0]       mod_reg, mod_next;
    hbkd_pkg::keys_t  keys_reg, keys_next;
    hbkd_pkg::mask_t  mask_reg, mask_next;

    logic             valid_reg, valid_next;
    logic [7:0]       omod_reg, omod_next;
    logic [7:0]       okey_reg, okey_next;
    hbkd_pkg::xlate_t ox_reg, ox_next;
    logic             olast_reg, olast_next;

    hbkd_pkg::mask_t  pick;
    hbkd_pkg::mask_t  rem;
    logic [7:0]       key;
    logic             fire;

    always_comb
    begin
        logic found;
        found = 1'b0;
        pick  = '0;
        key   = '0;
        for (int i = 0; i < hbkd_pkg::KEY_SLOTS; i++)
        begin
            if (mask_reg[i] && !found)
            begin
                found   = 1'b1;
                pick[i] = 1'b1;
                key     = keys_reg[i];
            end
        end
        rem  = mask_reg & ~pick;
        fire = (mask_reg != '0) && (!valid_reg || press.ready);
        pop  = q_valid && ((mask_reg == '0) || (fire && (rem == '0)));

        mod_next  = mod_reg;
        keys_next = keys_reg;
        mask_next = fire ? rem : mask_reg;
        if (pop)
        begin
            mod_next  = head.modifier;
            keys_next = head.keys;
            mask_next = head.mask;
        end

        valid_next = valid_reg && !press.ready;
        omod_next  = omod_reg;
        okey_next  = okey_reg;
        ox_next    = ox_reg;
        olast_next = olast_reg;
        if (fire)
        begin
            valid_next = 1'b1;
            omod_next  = mod_reg;
            okey_next  = key;
            ox_next    = hbkd_pkg::translate(mod_reg, key);
            olast_next = (rem == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg  <= mask_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mod_reg   <= mod_next;
        keys_reg  <= keys_next;
        omod_reg  <= omod_next;
        okey_reg  <= okey_next;
        ox_reg    <= ox_next;
        olast_reg <= olast_next;
    end

    assign press.valid          = valid_reg;
    assign press.press_modifier = omod_reg;
    assign press.press_keycode  = okey_reg;
    assign press.event_kind     = ox_reg.kind;
    assign press.dir_index      = ox_reg.joy;
    assign press.char_value     = ox_reg.chr;
    assign press.last_of_report = olast_reg;

endmodule

`default_nettype wire

// File: design/hid_boot_report_key_press_decoder_core.sv
// HID boot keyboard report decoder, top level.
// Channels: report (sink) takes one boot report a word: modifier, six key
// slots and the received length; press (source) gives one word per new key
// press with the modifier, keycode and its joystick or ASCII translation,
// last_of_report marking the final press of a report.
// Reports shorter than 8 bytes are dropped and leave the stored keys alone;
// reports with no new press update the stored keys and give no word.
// Throughput: the back end emits one press per cycle while press.ready
// allows, and a report holds at most 6 new presses; the front end takes one
// report per cycle while the two-entry queue has room.
// Reset clears the stored keys to zero, empties the queue and drops the
// output word. When press.ready is low the output word holds, the back end
// stops, the queue fills and then report.ready drops.
// Depends on hbkd_pkg, the two channel interfaces, hbkd_front, hbkd_queue
// and hbkd_back.
`default_nettype none
`include "assert_macros.svh"

module hid_boot_report_key_press_decoder_core (
    input  wire logic     clk,
    input  wire logic     rst_n,
    hbkd_report_if.sink   report,
    hbkd_press_if.source  press
);

    hbkd_pkg::entry_t                  push_entry;
    hbkd_pkg::entry_t                  head;
    logic                              push;
    logic                              pop;
    logic                              q_valid;
    logic                              q_full;
    logic [hbkd_pkg::Q_CNT_W-1:0]      q_count;

    hbkd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .report     (report),
        .q_full     (q_full),
        .push_entry (push_entry),
        .push       (push)
    );

    hbkd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_valid    (q_valid),
        .q_full     (q_full),
        .count      (q_count)
    );

    hbkd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_valid (q_valid),
        .pop     (pop),
        .press   (press)
    );

    `HBKD_ASSERT(a_full_stalls, clk, rst_n, q_full |-> !report.ready, "queue full but ready")
    `HBKD_ASSERT(a_count_range, clk, rst_n, q_count <= hbkd_pkg::Q_CNT_W'(hbkd_pkg::Q_DEPTH), "queue overflow")
    `HBKD_ASSERT_ALWAYS(a_key_range, clk, !rst_n || !press.valid || press.press_keycode > hbkd_pkg::MAX_RESERVED, "reserved keycode emitted")
    `HBKD_ASSERT(a_char_unused, clk, rst_n, (press.valid && press.event_kind != hbkd_pkg::KIND_ASCII) |-> press.char_value == 7'd0, "char set without ASCII kind")

endmodule

`default_nettype wire
